FILE: hw/rtl/lfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsp_pkg
// Shared types and constants of the line follower steering PID.
// ----------------------------------------------------------------------------
package lfsp_pkg;

  localparam int LFSP_SAMPLE_BITS    = 10;
  localparam int LFSP_GAIN_FRAC_BITS = 8;

  localparam int GAIN_BITS    = 8;
  localparam int LIMIT_BITS   = 7;
  localparam int COUNT_BITS   = 16;
  localparam int INTEG_BITS   = 16;
  localparam int DRIVE_BITS   = 8;
  localparam int TARGET_BITS  = 8;
  localparam int CFG_IDX_BITS = 3;

  localparam int WHITE_RESET = 470;
  localparam int BLACK_RESET = 660;
  localparam logic [GAIN_BITS-1:0]  GAIN_PROP_RESET  = 8'd31;
  localparam logic [GAIN_BITS-1:0]  GAIN_DIFF_RESET  = 8'd20;
  localparam logic [GAIN_BITS-1:0]  GAIN_INTEG_RESET = 8'd38;
  localparam logic [LIMIT_BITS-1:0] STEER_LIMIT_RESET = 7'd100;
  localparam logic [LIMIT_BITS-1:0] STEER_SPEED_RESET = 7'd75;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WHITE_LEVEL = 3'd0,
    REG_BLACK_LEVEL = 3'd1,
    REG_GAIN_PROP   = 3'd2,
    REG_GAIN_DIFF   = 3'd3,
    REG_GAIN_INTEG  = 3'd4,
    REG_STEER_LIMIT = 3'd5,
    REG_STEER_SPEED = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0]  gain_prop;
    logic [GAIN_BITS-1:0]  gain_diff;
    logic [GAIN_BITS-1:0]  gain_integ;
    logic [LIMIT_BITS-1:0] steer_limit;
    logic [LIMIT_BITS-1:0] steer_speed;
  } cfg_fix_t;

endpackage

FILE: hw/rtl/lfsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsp_in_if / lfsp_out_if
// Valid/ready channels carrying the sample words and the result words.
// ----------------------------------------------------------------------------
interface lfsp_in_if
  import lfsp_pkg::*;
#(
  parameter int SAMPLE_BITS = LFSP_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [SAMPLE_BITS-1:0]        light_sample;
  logic signed [COUNT_BITS-1:0]  steer_count;

  modport source (output valid, light_sample, steer_count, input ready);
  modport sink   (input valid, light_sample, steer_count, output ready);
endinterface

interface lfsp_out_if
  import lfsp_pkg::*;
#(
  parameter int SAMPLE_BITS = LFSP_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [DRIVE_BITS-1:0]  steer_drive;
  logic                          steer_right;
  logic signed [TARGET_BITS-1:0] steer_target;
  logic signed [SAMPLE_BITS:0]   light_error;

  modport source (output valid, steer_drive, steer_right, steer_target, light_error,
                  input ready);
  modport sink   (input valid, steer_drive, steer_right, steer_target, light_error,
                  output ready);
endinterface

FILE: hw/rtl/lfsp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsp_cfg_regs
// Configuration registers: light references, gains, limit and speed.
// ----------------------------------------------------------------------------
module lfsp_cfg_regs
  import lfsp_pkg::*;
#(
  parameter int SAMPLE_BITS = LFSP_SAMPLE_BITS,
  parameter int CFG_BITS    = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output logic [SAMPLE_BITS-1:0]  white_level,
  output logic [SAMPLE_BITS-1:0]  black_level,
  output cfg_fix_t                fix
);

  logic [SAMPLE_BITS-1:0] white_r, white_nxt;
  logic [SAMPLE_BITS-1:0] black_r, black_nxt;
  cfg_fix_t               fix_r, fix_nxt;

  always_comb begin
    white_nxt = white_r;
    black_nxt = black_r;
    fix_nxt   = fix_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WHITE_LEVEL: white_nxt = cfg_data[SAMPLE_BITS-1:0];
        REG_BLACK_LEVEL: black_nxt = cfg_data[SAMPLE_BITS-1:0];
        REG_GAIN_PROP:   fix_nxt.gain_prop   = cfg_data[GAIN_BITS-1:0];
        REG_GAIN_DIFF:   fix_nxt.gain_diff   = cfg_data[GAIN_BITS-1:0];
        REG_GAIN_INTEG:  fix_nxt.gain_integ  = cfg_data[GAIN_BITS-1:0];
        REG_STEER_LIMIT: fix_nxt.steer_limit = cfg_data[LIMIT_BITS-1:0];
        REG_STEER_SPEED: fix_nxt.steer_speed = cfg_data[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r           <= SAMPLE_BITS'(WHITE_RESET);
      black_r           <= SAMPLE_BITS'(BLACK_RESET);
      fix_r.gain_prop   <= GAIN_PROP_RESET;
      fix_r.gain_diff   <= GAIN_DIFF_RESET;
      fix_r.gain_integ  <= GAIN_INTEG_RESET;
      fix_r.steer_limit <= STEER_LIMIT_RESET;
      fix_r.steer_speed <= STEER_SPEED_RESET;
    end else begin
      white_r <= white_nxt;
      black_r <= black_nxt;
      fix_r   <= fix_nxt;
    end
  end

  assign white_level = white_r;
  assign black_level = black_r;
  assign fix         = fix_r;

endmodule

FILE: hw/rtl/lfsp_pid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsp_pid_core
// One control step: steering drive, sample clamp, error, conditional
// integral, fixed-point PID sum and target clamp, with the loop state.
// ----------------------------------------------------------------------------
module lfsp_pid_core
  import lfsp_pkg::*;
#(
  parameter int SAMPLE_BITS    = LFSP_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = LFSP_GAIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [SAMPLE_BITS-1:0]        light_sample,
  input  logic signed [COUNT_BITS-1:0]  steer_count,
  input  logic [SAMPLE_BITS-1:0]        white_level,
  input  logic [SAMPLE_BITS-1:0]        black_level,
  input  cfg_fix_t                      fix,
  output logic signed [DRIVE_BITS-1:0]  steer_drive,
  output logic                          steer_right,
  output logic signed [TARGET_BITS-1:0] steer_target,
  output logic signed [SAMPLE_BITS:0]   light_error
);

  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int T_W    = ((ERR_W > INTEG_BITS) ? ERR_W : INTEG_BITS) + 1;
  localparam int SUM_W  = ((DIFF_W > INTEG_BITS) ? DIFF_W : INTEG_BITS) + GAIN_BITS + 3;
  localparam int Q_W    = SUM_W - GAIN_FRAC_BITS;
  localparam logic signed [T_W-1:0]   SAT_HI     = T_W'(32767);
  localparam logic signed [T_W-1:0]   SAT_LO     = T_W'(-32768);
  localparam logic [SUM_W-1:0]        ROUND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

  logic signed [ERR_W-1:0]       prev_error_r, prev_error_nxt;
  logic signed [INTEG_BITS-1:0]  integ_sum_r, integ_sum_nxt;
  logic signed [TARGET_BITS-1:0] target_pos_r, target_pos_nxt;
  logic                          turn_dir_r, turn_dir_nxt;

  logic signed [COUNT_BITS-1:0]  tgt_ext;
  logic                          brake;
  logic [DRIVE_BITS-1:0]         speed_ext;
  logic [SAMPLE_BITS-1:0]        sample_c;
  logic [SAMPLE_BITS:0]          ref_sum;
  logic [SAMPLE_BITS-1:0]        mid;
  logic signed [ERR_W-1:0]       err;
  logic                          at_limit;
  logic signed [T_W-1:0]         integ_t;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [GAIN_BITS:0]     gp_s, gd_s, gi_s;
  logic signed [SUM_W-1:0]       prod_p, prod_d, prod_i, sum;
  logic [SUM_W-1:0]              bias;
  logic signed [SUM_W-1:0]       sum_b;
  logic signed [Q_W-1:0]         q, lim_q, tq;

  always_comb begin
    tgt_ext   = COUNT_BITS'(target_pos_r);
    brake     = turn_dir_r ? (steer_count <= tgt_ext) : (steer_count >= tgt_ext);
    speed_ext = {1'b0, fix.steer_speed};
    if (brake) begin
      steer_drive = '0;
    end else if (turn_dir_r) begin
      steer_drive = -$signed(speed_ext);
    end else begin
      steer_drive = $signed(speed_ext);
    end
  end

  always_comb begin
    priority if (light_sample > black_level) begin
      sample_c = black_level;
    end else if (light_sample < white_level) begin
      sample_c = white_level;
    end else begin
      sample_c = light_sample;
    end
    ref_sum  = {1'b0, white_level} + {1'b0, black_level};
    mid      = ref_sum[SAMPLE_BITS:1];
    err      = $signed({1'b0, sample_c}) - $signed({1'b0, mid});
    at_limit = (sample_c == black_level) || (sample_c == white_level);

    integ_t = T_W'(err) + T_W'(integ_sum_r);
    priority if (!at_limit) begin
      integ_sum_nxt = '0;
    end else if (integ_t > SAT_HI) begin
      integ_sum_nxt = SAT_HI[INTEG_BITS-1:0];
    end else if (integ_t < SAT_LO) begin
      integ_sum_nxt = SAT_LO[INTEG_BITS-1:0];
    end else begin
      integ_sum_nxt = integ_t[INTEG_BITS-1:0];
    end

    diff = DIFF_W'(err) - DIFF_W'(prev_error_r);
    gp_s = $signed({1'b0, fix.gain_prop});
    gd_s = $signed({1'b0, fix.gain_diff});
    gi_s = $signed({1'b0, fix.gain_integ});
    prod_p = SUM_W'(gp_s) * SUM_W'(err);
    prod_d = SUM_W'(gd_s) * SUM_W'(diff);
    prod_i = SUM_W'(gi_s) * SUM_W'(integ_sum_nxt);
    sum    = prod_p + prod_d + prod_i;

    // Adding 2^F-1 to a negative sum makes the arithmetic shift round toward zero.
    bias  = sum[SUM_W-1] ? ROUND_BIAS : '0;
    sum_b = sum + $signed(bias);
    q     = $signed(sum_b[SUM_W-1:GAIN_FRAC_BITS]);
    lim_q = $signed(Q_W'({1'b0, fix.steer_limit}));
    priority if (q > lim_q) begin
      tq = lim_q;
    end else if (q < -lim_q) begin
      tq = -lim_q;
    end else begin
      tq = q;
    end

    target_pos_nxt = tq[TARGET_BITS-1:0];
    turn_dir_nxt   = err[ERR_W-1] || (err == '0);
    prev_error_nxt = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      integ_sum_r  <= '0;
      target_pos_r <= '0;
      turn_dir_r   <= 1'b0;
    end else if (step_en) begin
      prev_error_r <= prev_error_nxt;
      integ_sum_r  <= integ_sum_nxt;
      target_pos_r <= target_pos_nxt;
      turn_dir_r   <= turn_dir_nxt;
    end
  end

  assign steer_right  = turn_dir_nxt;
  assign steer_target = target_pos_nxt;
  assign light_error  = err;

  a_target_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> (TARGET_BITS'(target_pos_r) <= $signed({1'b0, $past(fix.steer_limit)}))
             && (target_pos_r >= -$signed({1'b0, $past(fix.steer_limit)})))
    else $error("steering target outside the limit");

  a_integ_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !at_limit) |=> (integ_sum_r == '0))
    else $error("integral kept while the sample is inside the references");

endmodule

FILE: hw/rtl/line_follow_steering_pid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_steering_pid
// Line follower steering controller with a conditional-integral PID loop.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  in_word   sink       light_sample, steer_count
//  out_word  source     steer_drive, steer_right, steer_target, light_error
//  cfg_*     write      cfg_index selects one of seven registers
//
// A word is registered on input and its result is registered on output;
// one word is accepted every cycle unless the output stalls. The loop state
// is updated as a word moves from the input register to the output register.
// A stalled output fills the input register and then holds in_word.ready low.
// Reset is synchronous; it loads the register defaults and clears the state.
// ----------------------------------------------------------------------------
module line_follow_steering_pid
  import lfsp_pkg::*;
#(
  parameter int SAMPLE_BITS    = LFSP_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = LFSP_GAIN_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  lfsp_in_if.sink                 in_word,
  lfsp_out_if.source              out_word,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [((SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS)-1:0] cfg_data
);

  localparam int CFG_BITS = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS;

  logic [SAMPLE_BITS-1:0]        white_level, black_level;
  cfg_fix_t                      fix;

  logic                          s1_v_r;
  logic [SAMPLE_BITS-1:0]        s1_sample_r;
  logic signed [COUNT_BITS-1:0]  s1_count_r;
  logic                          advance;
  logic                          in_take;

  logic signed [DRIVE_BITS-1:0]  drive_c;
  logic                          turn_c;
  logic signed [TARGET_BITS-1:0] target_c;
  logic signed [SAMPLE_BITS:0]   err_c;

  logic                          out_v_r;
  logic signed [DRIVE_BITS-1:0]  out_drive_r;
  logic                          out_turn_r;
  logic signed [TARGET_BITS-1:0] out_target_r;
  logic signed [SAMPLE_BITS:0]   out_err_r;

  lfsp_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CFG_BITS    (CFG_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .white_level (white_level),
    .black_level (black_level),
    .fix         (fix)
  );

  assign advance        = s1_v_r && (!out_v_r || out_word.ready);
  assign in_word.ready  = !s1_v_r || advance;
  assign in_take        = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_word.light_sample;
      s1_count_r  <= in_word.steer_count;
    end
  end

  lfsp_pid_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .light_sample (s1_sample_r),
    .steer_count  (s1_count_r),
    .white_level  (white_level),
    .black_level  (black_level),
    .fix          (fix),
    .steer_drive  (drive_c),
    .steer_right  (turn_c),
    .steer_target (target_c),
    .light_error  (err_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_r  <= drive_c;
      out_turn_r   <= turn_c;
      out_target_r <= target_c;
      out_err_r    <= err_c;
    end
  end

  assign out_word.valid        = out_v_r;
  assign out_word.steer_drive  = out_drive_r;
  assign out_word.steer_right  = out_turn_r;
  assign out_word.steer_target = out_target_r;
  assign out_word.light_error  = out_err_r;

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result register empty after a step");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> (s1_v_r && out_v_r && !out_word.ready))
    else $error("input stalled while the pipeline has room");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |=> (s1_v_r && $stable(s1_sample_r) && $stable(s1_count_r)))
    else $error("waiting input word lost or changed");

endmodule
